// ===== sv/cvsd_pkg.sv =====
// Package for the CAN vehicle signal decoder.
// Holds the frame and record payload types, CAN identifiers and decode constants.
// No dependencies.
package cvsd_pkg;

	// Received CAN frame, one transfer on the input channel
	typedef struct packed {
		logic [10:0] frame_id;
		logic        is_data_frame;
		logic [3:0]  byte_count;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic [7:0]  byte2;
		logic [7:0]  byte3;
		logic [7:0]  byte4;
		logic [7:0]  byte5;
		logic [7:0]  byte6;
		logic [7:0]  byte7;
	} in_t;

	// Dashboard signal record, one transfer on the output channel
	typedef struct packed {
		logic [7:0]  accelerator;
		logic [15:0] rpm_eighths;
		logic [15:0] speed_q8;
		logic        brake_pressed;
		logic        driver_door_open;
		logic        passenger_door_open;
		logic [1:0]  blinker_state;
		logic        fog_light_on;
		logic [1:0]  light_mode;
		logic        high_beam_on;
	} out_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ZERO_HOLD   = 2'd0,
		REG_RPM_LIMIT   = 2'd1,
		REG_SPEED_LIMIT = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [3:0]  ZERO_HOLD_RST   = 4'd10;
	localparam logic [15:0] RPM_LIMIT_RST   = 16'd56000;
	localparam logic [15:0] SPEED_LIMIT_RST = 16'd51200;

	// Frame identifiers
	localparam logic [10:0] ID_ENGINE_A = 11'h1F9;
	localparam logic [10:0] ID_ENGINE_B = 11'h284;
	localparam logic [10:0] ID_ROAD     = 11'h354;
	localparam logic [10:0] ID_PEDALS   = 11'h35D;
	localparam logic [10:0] ID_BODY     = 11'h60D;
	localparam logic [10:0] ID_LAMPS    = 11'h625;

	// Indicator lever codes in byte 7 of the body frame
	localparam logic [7:0] IND_LEFT_CODE   = 8'h36;
	localparam logic [7:0] IND_RIGHT_CODE  = 8'h56;
	localparam logic [7:0] IND_HAZARD_CODE = 8'h76;

	// Blinker state encoding
	localparam logic [1:0] BLINK_OFF    = 2'd0;
	localparam logic [1:0] BLINK_LEFT   = 2'd1;
	localparam logic [1:0] BLINK_RIGHT  = 2'd2;
	localparam logic [1:0] BLINK_HAZARD = 2'd3;

	// Light mode encoding
	localparam logic [1:0] LIGHT_OFF      = 2'd0;
	localparam logic [1:0] LIGHT_POSITION = 2'd1;
	localparam logic [1:0] LIGHT_DIPPED   = 2'd2;

	// Bit masks
	localparam logic [7:0] BRAKE_MASK     = 8'h10;
	localparam logic [7:0] DRV_DOOR_MASK  = 8'h08;
	localparam logic [7:0] PSG_DOOR_MASK  = 8'h10;
	localparam logic [7:0] FOG_MASK       = 8'h1C;
	localparam logic [7:0] DIPPED_MASK    = 8'h60;
	localparam logic [7:0] POSITION_MASK  = 8'h40;
	localparam logic [7:0] HIGH_BEAM_MASK = 8'h8C;

	// Road speed scaling: floor(raw * 256 / 90) = (raw * SPEED_MAGIC) >> SPEED_SHIFT,
	// exact for every 16-bit raw word (SPEED_MAGIC is 2^29 / 45 rounded up, that is 128/45 scaled by 2^22)
	localparam int          SPEED_SHIFT = 22;
	localparam logic [23:0] SPEED_MAGIC = 24'd11930465;

	// Saturation point of the zero-reading counters
	localparam logic [4:0] ZERO_CNT_MAX = 5'd31;

endpackage

// ===== sv/can_vehicle_signal_decoder.sv =====
// CAN vehicle signal decoder: top level.
// Depends on cvsd_pkg for payload types, identifiers and constants.
//
// Usage
// - Input channel (in_valid / in_stall / in_data) carries one received CAN
//   frame per transfer. Output channel (out_valid / out_stall / out_data)
//   returns the whole dashboard record once for every frame taken.
// - Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes hold count, rpm limit and speed limit; cfg_ready is always high.
//   Write only while no frame is in flight.
// - Path: a taken frame is held in the input register, decoded from there,
//   and its record is registered and presented on out_data.
// - Throughput: one frame per cycle while the receiver does not stall. The
//   record register doubles as the decoder state, so each frame is decoded
//   against the record left by the previous one; the road-speed scaling
//   multiplier and its clamp compare set the logic depth of that decode.
// - Stall: while the receiver stalls, the record holds; one more frame can
//   wait in the input register, after which in_stall is raised.
// - Reset (arst_n low): registers return to their defaults, the record is
//   cleared and no transfer is pending on either side.
module can_vehicle_signal_decoder import cvsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// frame input
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	// record output
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [3:0]  zero_hold_q;
	logic [15:0] rpm_limit_q;
	logic [15:0] speed_limit_q;

	// input register
	logic        valid_s1;
	in_t         frame_s1;

	// record register (also the decoder state) and zero counters
	logic        out_valid_q;
	out_t        rec_q;
	logic [4:0]  rpm_zero_q;
	logic [4:0]  spd_zero_q;

	// decode signals
	logic        advance;
	logic        accept;
	logic [3:0]  len;
	logic [7:0]  b [8];
	logic [15:0] eng_raw;
	logic [15:0] road_raw;
	logic [39:0] road_prod;
	logic [17:0] road_scaled;
	out_t        rec_d;
	logic [4:0]  rpm_zero_d;
	logic [4:0]  spd_zero_d;
	logic [4:0]  rpm_zero_inc;
	logic [4:0]  spd_zero_inc;
	logic [4:0]  hold_plus1;

	// handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = rec_q;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_hold_q   <= ZERO_HOLD_RST;
			rpm_limit_q   <= RPM_LIMIT_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ZERO_HOLD:   zero_hold_q   <= cfg_data[3:0];
				REG_RPM_LIMIT:   rpm_limit_q   <= cfg_data;
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= in_data;
		end
	end

	// length clamp and masking of bytes past the frame length
	always_comb begin
		len  = (frame_s1.byte_count > 4'd8) ? 4'd8 : frame_s1.byte_count;
		b[0] = (len > 4'd0) ? frame_s1.byte0 : 8'd0;
		b[1] = (len > 4'd1) ? frame_s1.byte1 : 8'd0;
		b[2] = (len > 4'd2) ? frame_s1.byte2 : 8'd0;
		b[3] = (len > 4'd3) ? frame_s1.byte3 : 8'd0;
		b[4] = (len > 4'd4) ? frame_s1.byte4 : 8'd0;
		b[5] = (len > 4'd5) ? frame_s1.byte5 : 8'd0;
		b[6] = (len > 4'd6) ? frame_s1.byte6 : 8'd0;
		b[7] = (len > 4'd7) ? frame_s1.byte7 : 8'd0;
	end

	// raw words and road speed scaling
	assign eng_raw     = {b[2], b[3]};
	assign road_raw    = {b[0], b[1]};
	assign road_prod   = {24'd0, road_raw} * {16'd0, SPEED_MAGIC};
	assign road_scaled = road_prod[SPEED_SHIFT +: 18];

	// saturating zero counters
	assign hold_plus1   = {1'b0, zero_hold_q} + 5'd1;
	assign rpm_zero_inc = (rpm_zero_q < ZERO_CNT_MAX) ? rpm_zero_q + 5'd1 : ZERO_CNT_MAX;
	assign spd_zero_inc = (spd_zero_q < ZERO_CNT_MAX) ? spd_zero_q + 5'd1 : ZERO_CNT_MAX;

	// frame decode against the current record
	always_comb begin
		rec_d      = rec_q;
		rpm_zero_d = rpm_zero_q;
		spd_zero_d = spd_zero_q;
		if (frame_s1.is_data_frame) begin
			case (frame_s1.frame_id)
				ID_ENGINE_A, ID_ENGINE_B: begin
					rec_d.accelerator = b[2];
					if (len >= 4'd4) begin
						if (eng_raw != 16'd0) begin
							rec_d.rpm_eighths = (eng_raw > rpm_limit_q) ? rpm_limit_q : eng_raw;
							rpm_zero_d        = 5'd0;
						end else if (rpm_zero_inc > {1'b0, zero_hold_q}) begin
							rec_d.rpm_eighths = 16'd0;
							rpm_zero_d        = hold_plus1;
						end else begin
							rpm_zero_d = rpm_zero_inc;
						end
					end
				end
				ID_ROAD: begin
					if (len >= 4'd2) begin
						if (road_raw != 16'd0) begin
							rec_d.speed_q8 = (road_scaled > {2'b00, speed_limit_q}) ?
								speed_limit_q : road_scaled[15:0];
							spd_zero_d     = 5'd0;
						end else if (spd_zero_inc > {1'b0, zero_hold_q}) begin
							rec_d.speed_q8 = 16'd0;
							spd_zero_d     = hold_plus1;
						end else begin
							spd_zero_d = spd_zero_inc;
						end
					end
				end
				ID_PEDALS: begin
					rec_d.brake_pressed = |(b[4] & BRAKE_MASK);
				end
				ID_BODY: begin
					if (len >= 4'd8) begin
						rec_d.driver_door_open    = |(b[0] & DRV_DOOR_MASK);
						rec_d.passenger_door_open = |(b[0] & PSG_DOOR_MASK);
					end
					case (b[7])
						IND_LEFT_CODE:   rec_d.blinker_state = BLINK_LEFT;
						IND_RIGHT_CODE:  rec_d.blinker_state = BLINK_RIGHT;
						IND_HAZARD_CODE: rec_d.blinker_state = BLINK_HAZARD;
						default:         rec_d.blinker_state = BLINK_OFF;
					endcase
					rec_d.fog_light_on = ((b[6] & FOG_MASK) == FOG_MASK);
				end
				ID_LAMPS: begin
					if (len >= 4'd2) begin
						if ((b[1] & DIPPED_MASK) == DIPPED_MASK) begin
							rec_d.light_mode = LIGHT_DIPPED;
						end else if (|(b[1] & POSITION_MASK)) begin
							rec_d.light_mode = LIGHT_POSITION;
						end else begin
							rec_d.light_mode = LIGHT_OFF;
						end
						rec_d.high_beam_on = |(b[1] & HIGH_BEAM_MASK);
					end
				end
				default: ;
			endcase
		end
	end

	// record register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_q       <= '0;
			rpm_zero_q  <= 5'd0;
			spd_zero_q  <= 5'd0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				rec_q       <= rec_d;
				rpm_zero_q  <= rpm_zero_d;
				spd_zero_q  <= spd_zero_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/tb_can_vehicle_signal_decoder.sv =====
// Self-checking testbench for the CAN vehicle signal decoder.
// Drives CAN frames and register writes, and checks every dashboard record against an
// in-bench decoder model. Depends on cvsd_pkg and can_vehicle_signal_decoder.
`timescale 1ns / 100ps

module tb_can_vehicle_signal_decoder;
	import cvsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_OFF_CYCLES = 240;

	// Expected-record tracker: decodes each accepted frame and checks records in order
	class record_tracker;
		logic [3:0]  hold_cnt;
		logic [15:0] rpm_lim;
		logic [15:0] spd_lim;
		logic [7:0]  accel;
		logic [15:0] eng_spd;
		logic [15:0] road_spd;
		logic        brake, drv_door, psg_door, fog, high_beam;
		logic [1:0]  blink, lamp;
		logic [4:0]  rpm_zeros, spd_zeros;
		out_t        due_records[$];
		int          errors;
		int          frames;
		int          records;
		int          writes;

		function new();
			hold_cnt = ZERO_HOLD_RST;
			rpm_lim = RPM_LIMIT_RST;
			spd_lim = SPEED_LIMIT_RST;
			accel = '0;
			eng_spd = '0;
			road_spd = '0;
			{brake, drv_door, psg_door, fog, high_beam} = '0;
			blink = BLINK_OFF;
			lamp = LIGHT_OFF;
			rpm_zeros = '0;
			spd_zeros = '0;
			errors = 0;
			frames = 0;
			records = 0;
			writes = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			writes++;
			case (idx)
				REG_ZERO_HOLD:   hold_cnt = val[3:0];
				REG_RPM_LIMIT:   rpm_lim = val;
				REG_SPEED_LIMIT: spd_lim = val;
				default: ;
			endcase
		endfunction

		// Speed word with zero-reading debounce
		function void follow_word(input logic [15:0] raw, input logic [15:0] lim,
				inout logic [15:0] val, inout logic [4:0] cnt);
			if (raw != 0) begin
				val = (raw > lim) ? lim : raw;
				cnt = '0;
			end else begin
				if (cnt < ZERO_CNT_MAX)
					cnt = cnt + 5'd1;
				if (cnt > {1'b0, hold_cnt}) begin
					val = '0;
					cnt = {1'b0, hold_cnt} + 5'd1;
				end
			end
		endfunction

		function void take_frame(in_t f);
			logic [63:0] pl;
			logic [7:0]  b[8];
			int unsigned len;
			logic [15:0] word;
			logic [31:0] q8;
			out_t        e;
			frames++;
			len = (f.byte_count > 8) ? 8 : f.byte_count;
			pl = {f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7};
			// bytes past the frame length read as zero
			for (int i = 0; i < 8; i++)
				b[i] = (i < len) ? pl[63 - 8 * i -: 8] : 8'h00;
			if (f.is_data_frame) begin
				case (f.frame_id)
					ID_ENGINE_A, ID_ENGINE_B: begin
						accel = b[2];
						if (len >= 4)
							follow_word({b[2], b[3]}, rpm_lim, eng_spd, rpm_zeros);
					end
					ID_ROAD: begin
						if (len >= 2) begin
							word = {b[0], b[1]};
							q8 = ({16'h0, word} * 32'd256) / 32'd90;
							if (word != 0) begin
								road_spd = (q8 > {16'h0, spd_lim}) ? spd_lim : q8[15:0];
								spd_zeros = '0;
							end else begin
								follow_word(16'h0, spd_lim, road_spd, spd_zeros);
							end
						end
					end
					ID_PEDALS: brake = (b[4] & BRAKE_MASK) != 0;
					ID_BODY: begin
						if (len >= 8) begin
							drv_door = (b[0] & DRV_DOOR_MASK) != 0;
							psg_door = (b[0] & PSG_DOOR_MASK) != 0;
						end
						if (b[7] == IND_LEFT_CODE)
							blink = BLINK_LEFT;
						else if (b[7] == IND_RIGHT_CODE)
							blink = BLINK_RIGHT;
						else if (b[7] == IND_HAZARD_CODE)
							blink = BLINK_HAZARD;
						else
							blink = BLINK_OFF;
						fog = (b[6] & FOG_MASK) == FOG_MASK;
					end
					ID_LAMPS: begin
						if (len >= 2) begin
							if ((b[1] & DIPPED_MASK) == DIPPED_MASK)
								lamp = LIGHT_DIPPED;
							else if ((b[1] & POSITION_MASK) != 0)
								lamp = LIGHT_POSITION;
							else
								lamp = LIGHT_OFF;
							high_beam = (b[1] & HIGH_BEAM_MASK) != 0;
						end
					end
					default: ;
				endcase
			end
			e.accelerator = accel;
			e.rpm_eighths = eng_spd;
			e.speed_q8 = road_spd;
			e.brake_pressed = brake;
			e.driver_door_open = drv_door;
			e.passenger_door_open = psg_door;
			e.blinker_state = blink;
			e.fog_light_on = fog;
			e.light_mode = lamp;
			e.high_beam_on = high_beam;
			due_records.push_back(e);
		endfunction

		function void cmp(string name, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void match_record(out_t r);
			out_t e;
			records++;
			if (due_records.size() == 0) begin
				$error("record transfer with no frame outstanding");
				errors++;
				return;
			end
			e = due_records.pop_front();
			cmp("accelerator", e.accelerator, r.accelerator);
			cmp("rpm_eighths", e.rpm_eighths, r.rpm_eighths);
			cmp("speed_q8", e.speed_q8, r.speed_q8);
			cmp("brake_pressed", e.brake_pressed, r.brake_pressed);
			cmp("driver_door_open", e.driver_door_open, r.driver_door_open);
			cmp("passenger_door_open", e.passenger_door_open, r.passenger_door_open);
			cmp("blinker_state", e.blinker_state, r.blinker_state);
			cmp("fog_light_on", e.fog_light_on, r.fog_light_on);
			cmp("light_mode", e.light_mode, r.light_mode);
			cmp("high_beam_on", e.high_beam_on, r.high_beam_on);
		endfunction

		function int pending();
			return due_records.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_ZERO_HOLD;
	logic [15:0] cfg_data = '0;

	record_tracker tracker = new();
	int  cycles = 0;
	bit  send_calm = 1'b0;
	bit  recv_calm = 1'b0;
	bit  hold_off_req = 1'b0;
	int  hold_offs = 0;

	logic [10:0] known_ids[6] = '{ID_ENGINE_A, ID_ENGINE_B, ID_ROAD, ID_PEDALS, ID_BODY,
		ID_LAMPS};
	logic [7:0]  ind_codes[3] = '{IND_LEFT_CODE, IND_RIGHT_CODE, IND_HAZARD_CODE};

	can_vehicle_signal_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run-time guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[can_vehicle_signal_decoder] ERROR");
			$finish;
		end
	end

	// Transfer monitor: records are checked before the frame of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.match_record(out_data);
			if (in_valid && !in_stall)
				tracker.take_frame(in_data);
			if (cfg_valid && cfg_ready)
				tracker.write_reg(cfg_index, cfg_data);
		end
	end

	// Record receiver: random stall before each record, plus one long hold-off on request
	initial begin
		int n;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_calm = !recv_calm;
			n = recv_calm ? 0 : $urandom_range(0, 18);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_offs++;
				n = HOLD_OFF_CYCLES;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one frame; valid stays high into the next call when that one has no gap
	task automatic send_frame(in_t f);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic end_frames();
		in_valid <= 1'b0;
	endtask

	task automatic settle();
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic in_t frame(logic [10:0] id, logic data, logic [3:0] len,
			logic [63:0] bytes);
		return {id, data, len, bytes};
	endfunction

	// Random traffic: mostly decodable frames, zero-reading bursts, some noise
	task automatic run_random(int n);
		int   sent;
		int   r;
		int   burst;
		in_t  f;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				// run of zero readings, each on a randomly chosen speed word
				burst = $urandom_range(1, 20);
				for (int i = 0; i < burst; i++) begin
					f = frame(ID_ENGINE_A, 1'b1, 4'($urandom_range(4, 15)),
						{$urandom, $urandom});
					if ($urandom_range(0, 1)) begin
						f.frame_id = ID_ROAD;
						f.byte_count = 4'($urandom_range(2, 15));
						{f.byte0, f.byte1} = 16'h0;
					end else begin
						if ($urandom_range(0, 1))
							f.frame_id = ID_ENGINE_B;
						{f.byte2, f.byte3} = 16'h0;
					end
					send_frame(f);
					sent++;
				end
			end else if (r < 80) begin
				f = frame(known_ids[$urandom_range(0, 5)], 1'b1, 4'd8, {$urandom, $urandom});
				if ($urandom_range(0, 3) == 0)
					f.byte_count = 4'($urandom_range(0, 15));
				case (f.frame_id)
					ID_ENGINE_A, ID_ENGINE_B: begin
						if ($urandom_range(0, 3) == 0)
							f.byte2 = 8'($urandom_range(0, 3));
						if ($urandom_range(0, 7) == 0)
							{f.byte2, f.byte3} = 16'h0;
					end
					ID_ROAD: begin
						if ($urandom_range(0, 3) == 0)
							f.byte0 = 8'($urandom_range(0, 3));
						if ($urandom_range(0, 7) == 0)
							{f.byte0, f.byte1} = 16'h0;
					end
					ID_BODY: begin
						if ($urandom_range(0, 3) != 0)
							f.byte7 = ind_codes[$urandom_range(0, 2)];
						if ($urandom_range(0, 2) == 0)
							f.byte6 = f.byte6 | FOG_MASK;
					end
					default: ;
				endcase
				send_frame(f);
				sent++;
			end else if (r < 90) begin
				// remote and other non-data frames to decoded identifiers
				send_frame(frame(known_ids[$urandom_range(0, 5)], 1'b0,
					4'($urandom_range(0, 15)), {$urandom, $urandom}));
				sent++;
			end else begin
				f = frame(11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)), {$urandom, $urandom});
				send_frame(f);
				sent++;
			end
		end
		end_frames();
	endtask

	task automatic run_phase(logic [3:0] hold, logic [15:0] rpm_lim, logic [15:0] spd_lim,
			int n, bit hold_off);
		write_reg(REG_ZERO_HOLD, {12'($urandom), hold});
		write_reg(REG_RPM_LIMIT, rpm_lim);
		write_reg(REG_SPEED_LIMIT, spd_lim);
		write_reg(REG_UNUSED, 16'($urandom));
		if (hold_off)
			hold_off_req = 1'b1;
		run_random(n);
		settle();
	endtask

	// Stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset register values
		send_frame(frame(ID_ENGINE_A, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
		send_frame(frame(ID_ENGINE_B, 1'b1, 4'd4, 64'h1111_0001_2222_3333));
		send_frame(frame(ID_ENGINE_A, 1'b1, 4'd3, 64'h0000_5AA5_0000_0000));
		send_frame(frame(ID_ENGINE_A, 1'b1, 4'd15, 64'h0000_8000_0000_0000));
		send_frame(frame(ID_ENGINE_A, 1'b1, 4'd8, 64'hFFFF_0000_FFFF_FFFF));
		send_frame(frame(ID_ROAD, 1'b1, 4'd2, 64'hFFFF_0000_0000_0000));
		send_frame(frame(ID_ROAD, 1'b1, 4'd1, 64'h0101_0000_0000_0000));
		send_frame(frame(ID_ROAD, 1'b1, 4'd8, 64'h0001_FFFF_FFFF_FFFF));
		send_frame(frame(ID_ROAD, 1'b1, 4'd2, 64'h0000_FFFF_FFFF_FFFF));
		send_frame(frame(ID_PEDALS, 1'b1, 4'd8, 64'h0000_0000_1000_0000));
		send_frame(frame(ID_PEDALS, 1'b1, 4'd4, 64'h0000_0000_FF00_0000));
		send_frame(frame(ID_BODY, 1'b1, 4'd8, 64'h1800_0000_0000_1C36));
		send_frame(frame(ID_BODY, 1'b1, 4'd8, 64'h0800_0000_0000_0056));
		send_frame(frame(ID_BODY, 1'b1, 4'd8, 64'h1000_0000_0000_0C76));
		send_frame(frame(ID_BODY, 1'b1, 4'd7, 64'hFFFF_FFFF_FFFF_FF36));
		send_frame(frame(ID_BODY, 1'b1, 4'd8, 64'h0000_0000_0000_E337));
		send_frame(frame(ID_LAMPS, 1'b1, 4'd2, 64'h0060_0000_0000_0000));
		send_frame(frame(ID_LAMPS, 1'b1, 4'd8, 64'h0044_0000_0000_0000));
		send_frame(frame(ID_LAMPS, 1'b1, 4'd8, 64'h00A0_0000_0000_0000));
		send_frame(frame(ID_LAMPS, 1'b1, 4'd2, 64'h0008_0000_0000_0000));
		send_frame(frame(ID_LAMPS, 1'b1, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF));
		send_frame(frame(ID_ENGINE_A, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
		send_frame(frame(11'h7FF, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
		send_frame(frame(11'h000, 1'b1, 4'd0, 64'h0000_0000_0000_0000));
		send_frame(frame(ID_PEDALS, 1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
		end_frames();
		settle();

		// register settings: extremes, tight limits, random, reset values under pressure, then random low limits
		run_phase(4'd0, 16'd0, 16'd0, 250, 1'b0);
		run_phase(4'd15, 16'hFFFF, 16'hFFFF, 300, 1'b0);
		run_phase(4'd1, 16'd1000, 16'd300, 250, 1'b0);
		run_phase(4'($urandom), 16'($urandom), 16'($urandom), 250, 1'b0);
		run_phase(4'($urandom), 16'($urandom), 16'($urandom), 250, 1'b0);
		run_phase(ZERO_HOLD_RST, RPM_LIMIT_RST, SPEED_LIMIT_RST, 300, 1'b1);
		run_phase(4'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
			300, 1'b0);

		$display("Checked %0d records from %0d frames over %0d register writes.",
			tracker.records, tracker.frames, tracker.writes);
		$display("Hold counts 0 to 15, zero and full-scale limits, %0d long output hold-off(s).",
			hold_offs);
		if (tracker.errors == 0)
			$display("[can_vehicle_signal_decoder] OK");
		else
			$display("[can_vehicle_signal_decoder] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/cvsd_pkg.sv
sv/can_vehicle_signal_decoder.sv
tb/tb_can_vehicle_signal_decoder.sv
